// ----- rtl/imsf_pkg.sv -----
// ----------------------------------------------------------------------------
// imsf_pkg
// Shared types and constants of the Ising Metropolis spin flip block: field
// widths, register reset values, configuration register codes, the state
// encoding of the controller and the command and status bundles.
// ----------------------------------------------------------------------------
package imsf_pkg;

    // Field widths of the item, result and configuration registers.
    localparam int COORD_W  = 6;
    localparam int RND_W    = 16;
    localparam int SIDE_W   = 7;
    localparam int THRESH_W = 17;
    localparam int DE_W     = 5;
    localparam int ENERGY_W = 15;
    localparam int MAG_W    = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Default lattice capacity (rows and columns of stored spins).
    localparam int MAX_SIDE_DEFAULT = 64;

    // Register reset values.
    localparam int SIDE_RESET     = 64;
    localparam int THRESH_4_RESET = 1200;
    localparam int THRESH_8_RESET = 22;

    // The energy change is four times the number of agreeing neighbors, minus this.
    localparam int DE_OFFSET = 8;

    // Configuration register codes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIDE     = 2'd0,
        REG_THRESH_4 = 2'd1,
        REG_THRESH_8 = 2'd2
    } reg_idx_t;

    // Configuration register contents.
    typedef struct packed {
        logic [SIDE_W-1:0]   side;
        logic [THRESH_W-1:0] thresh_4;
        logic [THRESH_W-1:0] thresh_8;
    } cfg_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_BOOT_CLEAR,
        ST_IDLE,
        ST_READ_CENTER,
        ST_READ_MINUS,
        ST_READ_PLUS,
        ST_EVAL,
        ST_INIT_CLEAR,
        ST_PUSH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;       // take the item on the input ports
        logic rd_center;    // read the row of the site
        logic rd_minus;     // read the row above
        logic rd_plus;      // read the row below
        logic cap_center;   // capture site, left and right spins
        logic cap_minus;    // capture the upper neighbor
        logic eval;         // decide the flip and write back
        logic clear;        // write one row of spins up
        logic push;         // load the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_reinit;  // item on the input ports is a reinitialize request
        logic item_err;     // item on the input ports has a coordinate out of range
        logic clear_last;   // clearing pass is at its last row
        logic out_free;     // output register can take a result this cycle
    } status_t;

endpackage

// ----- rtl/imsf_ram.sv -----
// ----------------------------------------------------------------------------
// imsf_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module imsf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/imsf_cfg.sv -----
// ----------------------------------------------------------------------------
// imsf_cfg
// Configuration registers: lattice side and the two acceptance thresholds.
// ----------------------------------------------------------------------------
module imsf_cfg import imsf_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Register select; an index beyond the list changes nothing.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SIDE:     cfg_next.side     = cfg_data[SIDE_W-1:0];
                REG_THRESH_4: cfg_next.thresh_4 = cfg_data[THRESH_W-1:0];
                REG_THRESH_8: cfg_next.thresh_8 = cfg_data[THRESH_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.side     <= SIDE_W'(SIDE_RESET);
            cfg_reg.thresh_4 <= THRESH_W'(THRESH_4_RESET);
            cfg_reg.thresh_8 <= THRESH_W'(THRESH_8_RESET);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/imsf_ctrl.sv -----
// ----------------------------------------------------------------------------
// imsf_ctrl
// Controller of the spin flip block: sequences the row reads, the flip
// decision, the clearing passes and the hand-off to the output register.
// ----------------------------------------------------------------------------
module imsf_ctrl import imsf_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BOOT_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_BOOT_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.item_reinit)
                    begin
                        state_next = ST_INIT_CLEAR;
                    end
                    else if (status.item_err)
                    begin
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        state_next = ST_READ_CENTER;
                    end
                end
            end
            ST_READ_CENTER: state_next = ST_READ_MINUS;
            ST_READ_MINUS:  state_next = ST_READ_PLUS;
            ST_READ_PLUS:   state_next = ST_EVAL;
            ST_EVAL:        state_next = ST_PUSH;
            ST_INIT_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_BOOT_CLEAR:  cmd.clear = 1'b1;
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_READ_CENTER: cmd.rd_center = 1'b1;
            ST_READ_MINUS:
            begin
                cmd.rd_minus   = 1'b1;
                cmd.cap_center = 1'b1;
            end
            ST_READ_PLUS:
            begin
                cmd.rd_plus   = 1'b1;
                cmd.cap_minus = 1'b1;
            end
            ST_EVAL:        cmd.eval  = 1'b1;
            ST_INIT_CLEAR:  cmd.clear = 1'b1;
            ST_PUSH:        cmd.push  = status.out_free;
            default:        cmd = '0;
        endcase
    end

endmodule

// ----- rtl/imsf_dp.sv -----
// ----------------------------------------------------------------------------
// imsf_dp
// Datapath of the spin flip block: spin row memory, neighbor addressing,
// energy change and acceptance test, running totals and output register.
// ----------------------------------------------------------------------------
module imsf_dp import imsf_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  cmd_t                       cmd,
    output status_t                    status,
    input  logic                       req_type,
    input  logic [COORD_W-1:0]         col,
    input  logic [COORD_W-1:0]         row,
    input  logic [RND_W-1:0]           accept_random,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       accepted,
    output logic signed [DE_W-1:0]     delta_energy,
    output logic signed [ENERGY_W-1:0] energy,
    output logic signed [MAG_W-1:0]    magnetization,
    output logic                       coord_error
);

    localparam int AW = $clog2(MAX_SIDE);
    localparam int EFF_RESET = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;
    localparam int SQ_RESET  = EFF_RESET * EFF_RESET;
    localparam logic [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SQ_RESET);
    localparam logic [MAG_W-1:0]    MAG_RESET    = MAG_W'(SQ_RESET);

    // Effective side and coordinates of the incoming item.
    logic [SIDE_W-1:0] n;
    logic [SIDE_W-1:0] r7;
    logic [SIDE_W-1:0] c7;
    logic [SIDE_W-1:0] rm7;
    logic [SIDE_W-1:0] rp7;
    logic [SIDE_W-1:0] cm7;
    logic [SIDE_W-1:0] cp7;
    logic              coord_bad;

    // Item registers.
    logic [AW-1:0]    row_reg;
    logic [AW-1:0]    col_reg;
    logic [AW-1:0]    rm_reg;
    logic [AW-1:0]    rp_reg;
    logic [AW-1:0]    cm_reg;
    logic [AW-1:0]    cp_reg;
    logic [RND_W-1:0] rnd_reg;

    // Captured spins.
    logic [MAX_SIDE-1:0] row_data_reg;
    logic                s_reg;
    logic                left_reg;
    logic                right_reg;
    logic                up_reg;

    // Memory ports.
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [MAX_SIDE-1:0] ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [MAX_SIDE-1:0] ram_rdata;

    // Clearing pass row counter.
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;

    // Decision.
    logic                       down_bit;
    logic [2:0]                 agree;
    logic [DE_W-1:0]            de;
    logic                       flip;
    logic [MAX_SIDE-1:0]        flip_mask;
    logic [2*SIDE_W-1:0]        sq;

    // Totals and result staging.
    logic [ENERGY_W-1:0] energy_reg;
    logic [ENERGY_W-1:0] energy_next;
    logic [MAG_W-1:0]    mag_reg;
    logic [MAG_W-1:0]    mag_next;
    logic                acc_reg;
    logic [DE_W-1:0]     de_reg;
    logic                err_reg;

    // Output register.
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_acc_reg;
    logic [DE_W-1:0]     out_de_reg;
    logic [ENERGY_W-1:0] out_energy_reg;
    logic [MAG_W-1:0]    out_mag_reg;
    logic                out_err_reg;

    // Side in use saturates at the lattice capacity.
    always_comb
    begin
        if (int'(cfg.side) > MAX_SIDE)
        begin
            n = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            n = cfg.side;
        end
    end

    // Periodic neighbor coordinates, valid when the site is inside the lattice.
    always_comb
    begin
        r7        = SIDE_W'(row);
        c7        = SIDE_W'(col);
        coord_bad = (r7 >= n) || (c7 >= n);
        rm7       = (r7 == '0) ? n - SIDE_W'(1) : r7 - SIDE_W'(1);
        rp7       = (r7 + SIDE_W'(1) == n) ? '0 : r7 + SIDE_W'(1);
        cm7       = (c7 == '0) ? n - SIDE_W'(1) : c7 - SIDE_W'(1);
        cp7       = (c7 + SIDE_W'(1) == n) ? '0 : c7 + SIDE_W'(1);
    end

    // Reinitialize totals from the side squared.
    assign sq = (2 * SIDE_W)'(n) * (2 * SIDE_W)'(n);

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            row_reg <= AW'(r7);
            col_reg <= AW'(c7);
            rm_reg  <= AW'(rm7);
            rp_reg  <= AW'(rp7);
            cm_reg  <= AW'(cm7);
            cp_reg  <= AW'(cp7);
            rnd_reg <= accept_random;
        end
    end

    // Spin capture from the row reads.
    always_ff @(posedge clk)
    begin
        if (cmd.cap_center)
        begin
            row_data_reg <= ram_rdata;
            s_reg        <= ram_rdata[col_reg];
            left_reg     <= ram_rdata[cm_reg];
            right_reg    <= ram_rdata[cp_reg];
        end
        if (cmd.cap_minus)
        begin
            up_reg <= ram_rdata[col_reg];
        end
    end

    // Energy change is four per agreeing neighbor, less eight.
    always_comb
    begin
        down_bit = ram_rdata[col_reg];
        agree    = 3'(left_reg == s_reg) + 3'(right_reg == s_reg)
                 + 3'(up_reg == s_reg) + 3'(down_bit == s_reg);
        de       = {agree, 2'b00} - DE_W'(DE_OFFSET);
        case (agree)
            3'd3:    flip = {1'b0, rnd_reg} < cfg.thresh_4;
            3'd4:    flip = {1'b0, rnd_reg} < cfg.thresh_8;
            default: flip = 1'b1;
        endcase
        flip_mask          = '0;
        flip_mask[col_reg] = 1'b1;
    end

    // Memory access: clearing rows, row reads and the write-back of a flip.
    always_comb
    begin
        ram_re    = cmd.rd_center || cmd.rd_minus || cmd.rd_plus;
        ram_raddr = row_reg;
        if (cmd.rd_minus)
        begin
            ram_raddr = rm_reg;
        end
        else if (cmd.rd_plus)
        begin
            ram_raddr = rp_reg;
        end
        ram_we    = cmd.clear || (cmd.eval && flip);
        ram_waddr = cmd.clear ? clr_cnt_reg : row_reg;
        ram_wdata = cmd.clear ? '1 : (row_data_reg ^ flip_mask);
    end

    imsf_ram #(
        .WIDTH (MAX_SIDE),
        .DEPTH (MAX_SIDE)
    ) u_spin_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Clearing pass counter wraps back to row zero at the end of each pass.
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clear)
        begin
            if (status.clear_last)
            begin
                clr_cnt_next = '0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
        end
    end

    // Running totals.
    always_comb
    begin
        energy_next = energy_reg;
        mag_next    = mag_reg;
        if (cmd.accept && req_type)
        begin
            energy_next = ENERGY_W'(0) - {sq[MAG_W-1:0], 1'b0};
            mag_next    = sq[MAG_W-1:0];
        end
        else if (cmd.eval && flip)
        begin
            energy_next = energy_reg + {{(ENERGY_W - DE_W){de[DE_W-1]}}, de};
            mag_next    = s_reg ? mag_reg - MAG_W'(2) : mag_reg + MAG_W'(2);
        end
    end

    // Output register takes a result when empty or drained this cycle.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            energy_reg    <= ENERGY_RESET;
            mag_reg       <= MAG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            energy_reg    <= energy_next;
            mag_reg       <= mag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result staging and output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            acc_reg <= 1'b0;
            de_reg  <= '0;
            err_reg <= !req_type && coord_bad;
        end
        else if (cmd.eval)
        begin
            acc_reg <= flip;
            de_reg  <= de;
        end
        if (cmd.push)
        begin
            out_acc_reg    <= acc_reg;
            out_de_reg     <= de_reg;
            out_energy_reg <= energy_reg;
            out_mag_reg    <= mag_reg;
            out_err_reg    <= err_reg;
        end
    end

    // Status to the controller.
    always_comb
    begin
        status.item_reinit = req_type;
        status.item_err    = coord_bad;
        status.clear_last  = (clr_cnt_reg == AW'(MAX_SIDE - 1));
        status.out_free    = !out_valid_reg || !out_stall;
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = out_acc_reg;
    assign delta_energy  = out_de_reg;
    assign energy        = out_energy_reg;
    assign magnetization = out_mag_reg;
    assign coord_error   = out_err_reg;

endmodule

// ----- rtl/ising_metropolis_spin_flip.sv -----
// ----------------------------------------------------------------------------
// ising_metropolis_spin_flip
// Metropolis single-spin-flip step on a square Ising lattice with periodic
// wrap, keeping running energy and magnetization.
// ----------------------------------------------------------------------------
// Spins are stored one row per memory word, MAX_SIDE bits wide, in a single
// memory with one read and one write port, so a flip attempt reads the row of
// the site and the rows above and below one after another. A flip attempt
// steps through the three row reads, the evaluation and the push of its
// result; a request with a coordinate out of range goes straight to the push,
// and a reinitialize request rewrites every row to spin up, one row per cycle,
// before its push. After reset the block runs the same clearing pass over
// every row and holds in_stall high meanwhile; configuration writes are taken
// at all times. Each item gives exactly one result item, held in an output
// register so the next item can enter while the result waits to be taken.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_flip import imsf_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       req_type,
    input  logic [COORD_W-1:0]         col,
    input  logic [COORD_W-1:0]         row,
    input  logic [RND_W-1:0]           accept_random,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       accepted,
    output logic signed [DE_W-1:0]     delta_energy,
    output logic signed [ENERGY_W-1:0] energy,
    output logic signed [MAG_W-1:0]    magnetization,
    output logic                       coord_error
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    // Configuration registers.
    imsf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer.
    imsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Lattice, arithmetic and output register.
    imsf_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .status        (status),
        .req_type      (req_type),
        .col           (col),
        .row           (row),
        .accept_random (accept_random),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .accepted      (accepted),
        .delta_energy  (delta_energy),
        .energy        (energy),
        .magnetization (magnetization),
        .coord_error   (coord_error)
    );

endmodule
